[rtl/core/prplw_pkg.sv]
package prplw_pkg;

    localparam int COUNT_BITS = 32;
    localparam int CALC_BITS  = (COUNT_BITS > 28) ? COUNT_BITS : 28;
    localparam int ADDR_BITS  = 64;
    localparam int LEN_BITS   = 28;
    localparam int SLOT_BITS  = 24;
    localparam int SHIFT_BITS = 5;

    localparam logic [SHIFT_BITS-1:0] SHIFT_MIN   = 5'd12;
    localparam logic [SHIFT_BITS-1:0] SHIFT_MAX   = 5'd27;
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 5'd12;
    localparam logic [SHIFT_BITS-1:0] ENTRY_SHIFT = 5'd3;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    typedef enum logic [1:0] {
        RES_SEGMENT    = 2'd0,
        RES_FETCH      = 2'd1,
        RES_NULL       = 2'd2,
        RES_UNEXPECTED = 2'd3
    } result_kind_t;

    typedef struct packed {
        result_kind_t           kind;
        logic [ADDR_BITS-1:0]   address;
        logic [LEN_BITS-1:0]    length;
        logic                   last;
    } result_t;

endpackage

[rtl/core/nvme_prp_list_walker_unit.sv]
// Flow: an accepted item is registered, then processed into the result register once
// that register is empty or is handing over its last result.
// Throughput: one item per cycle while m_tready holds high and each item yields at most
// one result; an item that yields two holds off the next item, set by the two-slot result
// register draining one result a cycle.
// Reset (aresetn low, synchronous): walker idle, queues empty, page shift back to 12.
module nvme_prp_list_walker_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [4:0]    cfg_data,     // page_shift
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [223:0]  s_tdata,      // first_pointer, second_pointer, byte_count, entry_word
    input  logic          s_tuser,      // kind
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,      // address, length, zero pad
    output logic [1:0]    m_tuser,      // result_kind
    output logic          m_tlast       // last
);
    import prplw_pkg::*;

    logic [SHIFT_BITS-1:0] page_shift_reg;

    logic                  in_valid_reg, in_valid_next;
    logic                  in_kind_reg;
    logic [ADDR_BITS-1:0]  in_first_reg;
    logic [ADDR_BITS-1:0]  in_second_reg;
    logic [31:0]           in_count_reg;
    logic [ADDR_BITS-1:0]  in_entry_reg;

    logic [COUNT_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [ADDR_BITS-1:0]  fetch_address_reg, fetch_address_next;
    logic [SLOT_BITS-1:0]  slot_index_reg, slot_index_next;
    logic                  walking_reg, walking_next;

    result_t               out0_reg, out0_next;
    result_t               out1_reg, out1_next;
    logic [1:0]            out_cnt_reg, out_cnt_next;

    logic                  s_accept;
    logic                  pop;
    logic                  process;

    logic [SHIFT_BITS-1:0] shift_eff;
    logic [CALC_BITS-1:0]  page;
    logic [SLOT_BITS-1:0]  last_slot;
    logic [COUNT_BITS-1:0] count_trunc;
    logic [CALC_BITS-1:0]  count_ext;
    logic [CALC_BITS-1:0]  start_len;
    logic [CALC_BITS-1:0]  start_rem;
    logic [CALC_BITS-1:0]  left_ext;
    logic [CALC_BITS-1:0]  seg_len;
    logic [CALC_BITS-1:0]  left_after;
    result_t               r0;
    result_t               r1;
    logic [1:0]            nres;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;
    assign process   = in_valid_reg && ((out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && pop));
    assign s_tready  = !in_valid_reg || process;

    assign m_tvalid = (out_cnt_reg != 2'd0);
    assign m_tdata  = {4'b0, out0_reg.length, out0_reg.address};
    assign m_tuser  = out0_reg.kind;
    assign m_tlast  = out0_reg.last;

    always_comb begin
        if (page_shift_reg < SHIFT_MIN) begin
            shift_eff = SHIFT_MIN;
        end else if (page_shift_reg > SHIFT_MAX) begin
            shift_eff = SHIFT_MAX;
        end else begin
            shift_eff = page_shift_reg;
        end
        page        = CALC_BITS'(1) << shift_eff;
        last_slot   = (SLOT_BITS'(1) << (shift_eff - ENTRY_SHIFT)) - SLOT_BITS'(1);
        count_trunc = COUNT_BITS'(in_count_reg);
        count_ext   = CALC_BITS'(count_trunc);
        start_len   = (count_ext < page) ? count_ext : page;
        start_rem   = count_ext - start_len;
        left_ext    = CALC_BITS'(bytes_left_reg);
        seg_len     = (left_ext < page) ? left_ext : page;
        left_after  = left_ext - seg_len;
    end

    always_comb begin
        bytes_left_next    = bytes_left_reg;
        fetch_address_next = fetch_address_reg;
        slot_index_next    = slot_index_reg;
        walking_next       = walking_reg;
        r0                 = '{kind: RES_SEGMENT, address: '0, length: '0, last: 1'b1};
        r1                 = '{kind: RES_SEGMENT, address: '0, length: '0, last: 1'b1};
        nres               = 2'd0;
        if (in_kind_reg == KIND_START) begin
            walking_next    = 1'b0;
            bytes_left_next = '0;
            slot_index_next = '0;
            if (count_ext != '0) begin
                r0 = '{kind: RES_SEGMENT, address: in_first_reg,
                       length: LEN_BITS'(start_len), last: (start_rem == '0)};
                nres = 2'd1;
                if (start_rem != '0) begin
                    nres = 2'd2;
                    if (start_rem <= page) begin
                        r1 = '{kind: RES_SEGMENT, address: in_second_reg,
                               length: LEN_BITS'(start_rem), last: 1'b1};
                    end else begin
                        walking_next       = 1'b1;
                        bytes_left_next    = COUNT_BITS'(start_rem);
                        fetch_address_next = in_second_reg;
                        r1 = '{kind: RES_FETCH, address: in_second_reg,
                               length: '0, last: 1'b1};
                    end
                end
            end
        end else if (!walking_reg) begin
            r0   = '{kind: RES_UNEXPECTED, address: '0, length: '0, last: 1'b1};
            nres = 2'd1;
        end else if (in_entry_reg == '0) begin
            walking_next    = 1'b0;
            bytes_left_next = '0;
            r0   = '{kind: RES_NULL, address: '0, length: '0, last: 1'b1};
            nres = 2'd1;
        end else if ((slot_index_reg >= last_slot) && (left_ext > page)) begin
            fetch_address_next = in_entry_reg;
            slot_index_next    = '0;
            r0   = '{kind: RES_FETCH, address: in_entry_reg, length: '0, last: 1'b1};
            nres = 2'd1;
        end else begin
            bytes_left_next = COUNT_BITS'(left_after);
            if (left_after == '0) begin
                walking_next    = 1'b0;
                slot_index_next = '0;
                r0   = '{kind: RES_SEGMENT, address: in_entry_reg,
                         length: LEN_BITS'(seg_len), last: 1'b1};
                nres = 2'd1;
            end else begin
                slot_index_next    = slot_index_reg + SLOT_BITS'(1);
                fetch_address_next = fetch_address_reg + ADDR_BITS'(8);
                r0   = '{kind: RES_SEGMENT, address: in_entry_reg,
                         length: LEN_BITS'(seg_len), last: 1'b0};
                r1   = '{kind: RES_FETCH, address: fetch_address_reg + ADDR_BITS'(8),
                         length: '0, last: 1'b1};
                nres = 2'd2;
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end
        out0_next    = out0_reg;
        out1_next    = out1_reg;
        out_cnt_next = out_cnt_reg;
        if (process) begin
            out0_next    = r0;
            out1_next    = r1;
            out_cnt_next = nres;
        end else if (pop) begin
            out0_next    = out1_reg;
            out_cnt_next = out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg   <= s_tuser;
            in_first_reg  <= s_tdata[63:0];
            in_second_reg <= s_tdata[127:64];
            in_count_reg  <= s_tdata[159:128];
            in_entry_reg  <= s_tdata[223:160];
        end
        out0_reg <= out0_next;
        out1_reg <= out1_next;
        if (!aresetn) begin
            page_shift_reg    <= SHIFT_RESET;
            in_valid_reg      <= 1'b0;
            out_cnt_reg       <= 2'd0;
            bytes_left_reg    <= '0;
            fetch_address_reg <= '0;
            slot_index_reg    <= '0;
            walking_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                page_shift_reg <= cfg_data;
            end
            in_valid_reg <= in_valid_next;
            out_cnt_reg  <= out_cnt_next;
            if (process) begin
                bytes_left_reg    <= bytes_left_next;
                fetch_address_reg <= fetch_address_next;
                slot_index_reg    <= slot_index_next;
                walking_reg       <= walking_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg <= 2'd2)
        else $error("result count out of range");

    a_walk_left: assert property (@(posedge aclk) disable iff (!aresetn)
        walking_reg |-> (bytes_left_reg != '0))
        else $error("walking with no bytes left");

    a_pair_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_cnt_reg == 2'd2) |-> (out1_reg.last && !out0_reg.last))
        else $error("result pair with wrong last marking");

    a_nonseg_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != RES_SEGMENT)) |-> (m_tdata[91:64] == '0))
        else $error("non-segment result with length");
`endif

endmodule

[dv/tb_nvme_prp_list_walker_unit.sv]
`timescale 1ns / 100ps

module tb_nvme_prp_list_walker_unit;

    import prplw_pkg::*;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [4:0]    cfg_data;
    logic          s_tvalid;
    logic          s_tready;
    logic [223:0]  s_tdata;
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [95:0]   m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tlast;

    nvme_prp_list_walker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    logic [SHIFT_BITS-1:0] shift_cfg;
    logic [COUNT_BITS-1:0] left_bytes;
    logic [ADDR_BITS-1:0]  list_addr;
    logic [SLOT_BITS-1:0]  slot_no;
    logic                  walk_on;

    result_t pending_results[$];
    result_t due_result;
    int      mismatch_count;
    int      hold_left;
    bit      steady;

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int eff_shift();
        int s;
        s = shift_cfg;
        if (s < SHIFT_MIN) s = SHIFT_MIN;
        if (s > SHIFT_MAX) s = SHIFT_MAX;
        return s;
    endfunction

    function automatic logic [63:0] page_bytes();
        return 64'd1 << eff_shift();
    endfunction

    function automatic void push_result(result_kind_t k, logic [63:0] a, logic [63:0] len,
                                        logic l);
        result_t r;
        r.kind    = k;
        r.address = a;
        r.length  = len[LEN_BITS-1:0];
        r.last    = l;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_walk(logic kind, logic [63:0] p1, logic [63:0] p2,
                                         logic [31:0] cnt, logic [63:0] word);
        logic [63:0] page;
        logic [63:0] per_list;
        logic [63:0] n;
        logic [63:0] len;
        logic [63:0] rem;
        page     = page_bytes();
        per_list = page >> ENTRY_SHIFT;
        if (kind == KIND_START) begin
            n          = 64'(cnt);
            walk_on    = 1'b0;
            left_bytes = '0;
            slot_no    = '0;
            if (n == 0) return;
            len = (n < page) ? n : page;
            rem = n - len;
            push_result(RES_SEGMENT, p1, len, rem == 0);
            if (rem == 0) return;
            if (rem <= page) begin
                push_result(RES_SEGMENT, p2, rem, 1'b1);
                return;
            end
            walk_on    = 1'b1;
            left_bytes = rem[COUNT_BITS-1:0];
            list_addr  = p2;
            slot_no    = '0;
            push_result(RES_FETCH, list_addr, 64'd0, 1'b1);
        end else if (!walk_on) begin
            push_result(RES_UNEXPECTED, 64'd0, 64'd0, 1'b1);
        end else if (word == 0) begin
            walk_on    = 1'b0;
            left_bytes = '0;
            push_result(RES_NULL, 64'd0, 64'd0, 1'b1);
        end else if (64'(slot_no) >= per_list - 1 && 64'(left_bytes) > page) begin
            list_addr = word;
            slot_no   = '0;
            push_result(RES_FETCH, list_addr, 64'd0, 1'b1);
        end else begin
            len        = (64'(left_bytes) < page) ? 64'(left_bytes) : page;
            left_bytes = left_bytes - len[COUNT_BITS-1:0];
            if (left_bytes == 0) begin
                walk_on = 1'b0;
                slot_no = '0;
                push_result(RES_SEGMENT, word, len, 1'b1);
            end else begin
                push_result(RES_SEGMENT, word, len, 1'b0);
                slot_no   = slot_no + 1'b1;
                list_addr = list_addr + 64'd8;
                push_result(RES_FETCH, list_addr, 64'd0, 1'b1);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("error at %0t: %s got %0h, want %0h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, kind", 64'(m_tuser), 64'd0);
            end else begin
                due_result = pending_results.pop_front();
                if (m_tuser !== due_result.kind)
                    report_mismatch("kind", 64'(m_tuser), 64'(due_result.kind));
                if (m_tdata[63:0] !== due_result.address)
                    report_mismatch("address", m_tdata[63:0], due_result.address);
                if (m_tdata[91:64] !== due_result.length)
                    report_mismatch("length", 64'(m_tdata[91:64]), 64'(due_result.length));
                if (m_tlast !== due_result.last)
                    report_mismatch("last", 64'(m_tlast), 64'(due_result.last));
            end
        end
    end

    // hold off the receiver while hold_left runs down
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 13);
        end
    end

    task automatic send_item(input logic kind, input logic [63:0] p1, input logic [63:0] p2,
                             input logic [31:0] cnt, input logic [63:0] word);
        int gap;
        gap = (!steady && $urandom_range(99) < 13) ? $urandom_range(4, 1) : 0;
        @(negedge aclk);
        while (gap > 0) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            gap--;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {word, cnt, p2, p1};
        do @(posedge aclk); while (!s_tready);
        predict_walk(kind, p1, p2, cnt, word);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_shift(input logic [4:0] v);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        shift_cfg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic feed_list(input int max_entries);
        logic [63:0] base;
        int          n;
        base = rand_word() | 64'd1;
        n    = 0;
        while (walk_on && n < max_entries) begin
            send_item(KIND_ENTRY, rand_word(), rand_word(), $urandom,
                      base + (64'(n) << 12));
            n++;
        end
    endtask

    task automatic test_directed();
        send_item(KIND_START, '1, '1, 32'd0, '1);
        send_item(KIND_ENTRY, '0, '0, '0, '1);
        send_item(KIND_START, '1, '0, 32'd1, '0);
        send_item(KIND_START, 64'h1000, '1, 32'd4096, '0);
        send_item(KIND_START, 64'h2000, '1, 32'd4097, '0);
        send_item(KIND_START, 64'h3000, 64'h4000, 32'd8192, '0);
        // wrap the fetch address past the top
        send_item(KIND_START, 64'h5000, 64'hFFFF_FFFF_FFFF_FFF8, 32'd8193, '0);
        send_item(KIND_ENTRY, '0, '0, '0, 64'h6000);
        send_item(KIND_ENTRY, '0, '0, '0, '1);
        send_item(KIND_START, 64'h7000, 64'h8000, 32'd3 * 32'd4096, '0);
        send_item(KIND_ENTRY, '0, '0, '0, 64'h9000);
        send_item(KIND_ENTRY, '0, '0, '0, '0);
        send_item(KIND_ENTRY, '0, '0, '0, 64'hA000);
        send_item(KIND_START, 64'hB000, 64'hC000, 32'd5 * 32'd4096 + 32'd7, '0);
        send_item(KIND_ENTRY, '0, '0, '0, 64'hD000);
        send_item(KIND_START, 64'hE000, 64'hF000, 32'd2 * 32'd4096, '0);
        send_item(KIND_ENTRY, '0, '0, '0, 64'h1_0000);
        drain_results();
    endtask

    task automatic test_shift_extremes();
        write_shift(5'd0);
        send_item(KIND_START, rand_word(), rand_word(), 32'd3 * 32'd4096 + 32'd1, '0);
        feed_list(8);
        write_shift(5'd31);
        send_item(KIND_START, rand_word(), rand_word(), 32'hFFFF_FFFF, '0);
        feed_list(3);
        send_item(KIND_START, rand_word(), rand_word(), 32'd0, '0);
        write_shift(SHIFT_MAX);
        send_item(KIND_START, rand_word(), rand_word(), 32'h1000_0000, '0);
        send_item(KIND_START, rand_word(), rand_word(), 32'h1800_0001, '0);
        feed_list(4);
        write_shift(5'd11);
        send_item(KIND_START, rand_word(), rand_word(), 32'd4097, '0);
        write_shift(5'd28);
        send_item(KIND_START, rand_word(), rand_word(), 32'h0800_0001, '0);
        write_shift(SHIFT_MIN);
    endtask

    // walk the list at the larger page, then shrink it so the next entry lands on
    // the last slot with exactly one page left, which is data
    task automatic test_exact_list_end();
        write_shift(5'd13);
        send_item(KIND_START, rand_word(), rand_word(), 32'd512 * 32'd8192 + 32'd4096, '0);
        feed_list(150);
        steady = 1'b1;
        feed_list(200);
        steady = 1'b0;
        feed_list(161);
        write_shift(SHIFT_MIN);
        feed_list(4);
        drain_results();
    endtask

    task automatic test_backpressure();
        write_shift(SHIFT_MIN);
        @(posedge aclk);
        hold_left = 300;
        send_item(KIND_START, rand_word(), rand_word(), 32'd17 * 32'd4096, '0);
        feed_list(16);
        drain_results();
    endtask

    task automatic test_random();
        int          random_items;
        int          r;
        int          sel;
        int          pages;
        logic [63:0] page;
        logic [63:0] cnt64;
        logic [63:0] word;
        logic [4:0]  v;
        random_items = 0;
        while (random_items < 30) begin
            r = $urandom_range(99);
            if (r < 12) begin
                case ($urandom_range(3))
                    0: v = 5'($urandom_range(31));
                    1: v = SHIFT_MIN;
                    2: v = SHIFT_MAX;
                    default: v = 5'($urandom_range(16, 12));
                endcase
                write_shift(v);
            end else if (r < 17) begin
                send_item(KIND_ENTRY, rand_word(), rand_word(), $urandom, rand_word());
                random_items++;
            end else begin
                page = page_bytes();
                sel  = $urandom_range(99);
                if (sel < 4) begin
                    cnt64 = 64'd0;
                end else if (sel < 12 && eff_shift() >= 25) begin
                    cnt64 = 64'($urandom);
                end else begin
                    pages = $urandom_range(10);
                    cnt64 = 64'(pages) * page;
                    if (sel >= 50)
                        cnt64 = cnt64 + (64'($urandom) % page);
                    else if (sel >= 40)
                        cnt64 = cnt64 + page - 64'd1;
                end
                send_item(KIND_START, rand_word(), rand_word(), cnt64[31:0], rand_word());
                random_items++;
                while (walk_on) begin
                    r = $urandom_range(99);
                    if (r >= 6 && r < 9) break;
                    if (r < 3)
                        word = '0;
                    else if (r < 6)
                        word = '1;
                    else
                        word = rand_word();
                    send_item(KIND_ENTRY, rand_word(), rand_word(), $urandom, word);
                    random_items++;
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        m_tready       = 1'b0;
        hold_left      = 0;
        steady         = 1'b0;
        mismatch_count = 0;
        shift_cfg      = SHIFT_RESET;
        left_bytes     = '0;
        list_addr      = '0;
        slot_no        = '0;
        walk_on        = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_shift_extremes();
        test_exact_list_end();
        test_backpressure();
        test_random();
        drain_results();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
